>>> src/date_time_string_parser_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the date-time string parser
// Concurrent property wrappers used by the RTL file dtsp_back.
// ---------------------------------------------------------------------------
`ifndef DATE_TIME_STRING_PARSER_ASSERT_SVH
`define DATE_TIME_STRING_PARSER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define DTSP_ASSERT_NOW(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("dtsp assertion failed");

// next-cycle implication, disabled in reset
`define DTSP_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("dtsp assertion failed");

`endif

>>> src/dtsp_pkg.sv
// ---------------------------------------------------------------------------
// dtsp_pkg
// Types and constants shared by the date-time string parser.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package dtsp_pkg;

    localparam int LENGTH_BITS_DEF = 16;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [6:0] PIVOT_RESET = 7'd28;
    localparam logic [6:0] MONTH_MAX   = 7'd12;
    localparam logic [6:0] DAY_MAX     = 7'd31;
    localparam logic [6:0] HOUR_LIM    = 7'd24;
    localparam logic [6:0] MINSEC_LIM  = 7'd60;
    localparam logic [6:0] DEC_TEN     = 7'd10;
    localparam logic [7:0] YEAR_WRAP   = 8'd100;

    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_COLON   = 8'h3A;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_LEAD,
        PH_MON,
        PH_DAY,
        PH_YEAR,
        PH_GAP,
        PH_HOUR,
        PH_MIN,
        PH_SEC
    } t_phase;

    typedef struct packed {
        logic [7:0] char_code;
        logic       start_flag;
    } t_in;

    typedef struct packed {
        logic        status;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [7:0]  year;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [15:0] consumed_length;
    } t_out;

    typedef struct packed {
        logic       is_start;
        logic       is_digit;
        logic       is_ws;
        logic       is_slash;
        logic       is_colon;
        logic [3:0] value;
    } t_token;

endpackage

>>> src/dtsp_front.sv
// ---------------------------------------------------------------------------
// dtsp_front
// Classifies each incoming byte into a token for the parser queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtsp_front (
    input  dtsp_pkg::t_in    i_data,
    output dtsp_pkg::t_token o_tok
);

    logic [7:0] w_ch;
    logic [7:0] w_off;

    assign w_ch  = i_data.char_code;
    assign w_off = w_ch - dtsp_pkg::CH_DIGIT_0;

    always_comb begin
        o_tok.is_start = i_data.start_flag;
        o_tok.is_digit = (w_ch >= dtsp_pkg::CH_DIGIT_0) && (w_ch <= dtsp_pkg::CH_DIGIT_9);
        o_tok.is_ws    = (w_ch == dtsp_pkg::CH_SPACE)
                      || ((w_ch >= dtsp_pkg::CH_TAB) && (w_ch <= dtsp_pkg::CH_CR));
        o_tok.is_slash = (w_ch == dtsp_pkg::CH_SLASH);
        o_tok.is_colon = (w_ch == dtsp_pkg::CH_COLON);
        o_tok.value    = w_off[3:0];
    end

endmodule

>>> src/dtsp_fifo.sv
// ---------------------------------------------------------------------------
// dtsp_fifo
// Short token queue between the classifier and the parser.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtsp_fifo #(
    parameter int DEPTH = dtsp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  dtsp_pkg::t_token i_tok,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output dtsp_pkg::t_token o_tok
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    dtsp_pkg::t_token r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          w_do_push;
    logic          w_do_pop;

    assign o_full    = (r_count == FULL);
    assign o_valid   = (r_count != '0);
    assign o_tok     = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_do_pop && !w_do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_tok;
        end
    end

endmodule

>>> src/dtsp_back.sv
// ---------------------------------------------------------------------------
// dtsp_back
// Field parser state machine with range checks and result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "date_time_string_parser_assert.svh"

module dtsp_back #(
    parameter int LENGTH_BITS = dtsp_pkg::LENGTH_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [6:0]       i_cfg_wdata,
    input  logic             i_tok_valid,
    input  dtsp_pkg::t_token i_tok,
    output logic             o_tok_pop,
    output logic             o_out_valid,
    output dtsp_pkg::t_out   o_out_data,
    input  logic             i_out_stall
);

    dtsp_pkg::t_phase r_phase, n_phase;
    dtsp_pkg::t_phase w_phase_eff;
    dtsp_pkg::t_phase w_field;

    logic [6:0]             r_pivot;
    logic [1:0]             r_dsc, n_dsc;
    logic [6:0]             r_acc, n_acc;
    logic [LENGTH_BITS-1:0] r_cnt, n_cnt;
    logic [3:0]             r_month, n_month;
    logic [4:0]             r_day, n_day;
    logic [7:0]             r_year, n_year;
    logic [4:0]             r_hour, n_hour;
    logic [5:0]             r_minute, n_minute;
    logic                   r_out_valid, n_out_valid;
    dtsp_pkg::t_out         r_out_data, n_out_data;

    logic                   w_pop;
    logic                   w_active;
    logic                   w_lead;
    logic                   w_skip;
    logic [1:0]             w_dsc;
    logic [6:0]             w_acc10;
    logic [6:0]             w_val;
    logic                   w_sep_ok;
    logic                   w_range_ok;
    logic                   w_second_dig;
    logic [LENGTH_BITS-1:0] w_cnt_eff;
    logic [LENGTH_BITS-1:0] w_cnt_inc;
    logic                   w_err;
    logic                   w_ok;

    assign w_pop       = i_tok_valid && (!r_out_valid || !i_out_stall);
    assign o_tok_pop   = w_pop;
    assign w_phase_eff = i_tok.is_start ? dtsp_pkg::PH_LEAD : r_phase;
    assign w_active    = w_pop && (w_phase_eff != dtsp_pkg::PH_IDLE);
    assign w_lead      = (w_phase_eff == dtsp_pkg::PH_LEAD) || (w_phase_eff == dtsp_pkg::PH_GAP);
    assign w_skip      = w_lead && i_tok.is_ws;
    assign w_dsc       = (i_tok.is_start || w_lead) ? 2'd0 : r_dsc;
    assign w_acc10     = ({3'b000, r_acc[3:0]} * dtsp_pkg::DEC_TEN) + {3'b000, i_tok.value};
    assign w_val       = i_tok.is_digit ? w_acc10 : r_acc;
    assign w_second_dig = (w_dsc == 2'd1) && i_tok.is_digit;
    assign w_cnt_eff   = i_tok.is_start ? '0 : r_cnt;
    assign w_cnt_inc   = (w_cnt_eff == '1) ? w_cnt_eff : w_cnt_eff + 1'b1;

    always_comb begin
        case (w_phase_eff)
            dtsp_pkg::PH_LEAD: w_field = dtsp_pkg::PH_MON;
            dtsp_pkg::PH_GAP:  w_field = dtsp_pkg::PH_HOUR;
            default:           w_field = w_phase_eff;
        endcase
    end

    always_comb begin
        w_sep_ok   = i_tok.is_colon;
        w_range_ok = 1'b0;
        case (w_field)
            dtsp_pkg::PH_MON: begin
                w_sep_ok   = i_tok.is_slash;
                w_range_ok = (r_acc != '0) && (r_acc <= dtsp_pkg::MONTH_MAX);
            end
            dtsp_pkg::PH_DAY: begin
                w_sep_ok   = i_tok.is_slash;
                w_range_ok = (r_acc != '0) && (r_acc <= dtsp_pkg::DAY_MAX);
            end
            dtsp_pkg::PH_HOUR: w_range_ok = (r_acc < dtsp_pkg::HOUR_LIM);
            dtsp_pkg::PH_MIN:  w_range_ok = (r_acc < dtsp_pkg::MINSEC_LIM);
            default:           w_range_ok = 1'b0;
        endcase
    end

    always_comb begin
        w_err = 1'b0;
        w_ok  = 1'b0;
        if (w_active && !w_skip) begin
            if (w_dsc == 2'd0) begin
                w_err = !i_tok.is_digit;
            end else begin
                case (w_field)
                    dtsp_pkg::PH_SEC: begin
                        w_err = (w_val >= dtsp_pkg::MINSEC_LIM);
                        w_ok  = (w_val < dtsp_pkg::MINSEC_LIM);
                    end
                    dtsp_pkg::PH_YEAR: w_err = !(i_tok.is_digit || i_tok.is_ws);
                    default: begin
                        if (!w_second_dig) begin
                            w_err = !w_sep_ok || !w_range_ok;
                        end
                    end
                endcase
            end
        end
    end

    always_comb begin
        n_phase = r_phase;
        if (w_active) begin
            if (w_err || w_ok) begin
                n_phase = dtsp_pkg::PH_IDLE;
            end else if (w_skip) begin
                n_phase = w_phase_eff;
            end else if (w_dsc == 2'd0) begin
                n_phase = w_field;
            end else begin
                case (w_field)
                    dtsp_pkg::PH_YEAR: n_phase = dtsp_pkg::PH_GAP;
                    dtsp_pkg::PH_MON:  n_phase = w_second_dig ? w_field : dtsp_pkg::PH_DAY;
                    dtsp_pkg::PH_DAY:  n_phase = w_second_dig ? w_field : dtsp_pkg::PH_YEAR;
                    dtsp_pkg::PH_HOUR: n_phase = w_second_dig ? w_field : dtsp_pkg::PH_MIN;
                    dtsp_pkg::PH_MIN:  n_phase = w_second_dig ? w_field : dtsp_pkg::PH_SEC;
                    default:           n_phase = w_field;
                endcase
            end
        end
    end

    always_comb begin
        n_dsc       = r_dsc;
        n_acc       = r_acc;
        n_cnt       = r_cnt;
        n_month     = r_month;
        n_day       = r_day;
        n_year      = r_year;
        n_hour      = r_hour;
        n_minute    = r_minute;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_data  = r_out_data;
        if (w_active) begin
            n_cnt = w_cnt_eff;
            if (w_skip) begin
                n_cnt = w_cnt_inc;
            end else if (w_dsc == 2'd0) begin
                if (i_tok.is_digit) begin
                    n_acc = {3'b000, i_tok.value};
                    n_dsc = 2'd1;
                    n_cnt = w_cnt_inc;
                end
            end else begin
                case (w_field)
                    dtsp_pkg::PH_SEC: begin
                        if (i_tok.is_digit) begin
                            n_cnt = w_cnt_inc;
                        end
                    end
                    dtsp_pkg::PH_YEAR: begin
                        if (i_tok.is_digit || i_tok.is_ws) begin
                            n_cnt  = w_cnt_inc;
                            n_year = (w_val < r_pivot) ? {1'b0, w_val} + dtsp_pkg::YEAR_WRAP
                                                       : {1'b0, w_val};
                            n_dsc  = 2'd0;
                            n_acc  = '0;
                        end
                    end
                    default: begin
                        if (w_second_dig) begin
                            n_acc = w_acc10;
                            n_dsc = 2'd2;
                            n_cnt = w_cnt_inc;
                        end else if (w_sep_ok) begin
                            n_cnt = w_cnt_inc;
                            if (w_range_ok) begin
                                n_dsc = 2'd0;
                                n_acc = '0;
                                case (w_field)
                                    dtsp_pkg::PH_MON:  n_month  = r_acc[3:0];
                                    dtsp_pkg::PH_DAY:  n_day    = r_acc[4:0];
                                    dtsp_pkg::PH_HOUR: n_hour   = r_acc[4:0];
                                    default:           n_minute = r_acc[5:0];
                                endcase
                            end
                        end
                    end
                endcase
            end
        end
        if (w_err) begin
            n_out_valid       = 1'b1;
            n_out_data        = '0;
            n_out_data.status = 1'b1;
        end else if (w_ok) begin
            n_out_valid                = 1'b1;
            n_out_data.status          = 1'b0;
            n_out_data.month           = r_month;
            n_out_data.day             = r_day;
            n_out_data.year            = r_year;
            n_out_data.hour            = r_hour;
            n_out_data.minute          = r_minute;
            n_out_data.second          = w_val[5:0];
            n_out_data.consumed_length = 16'(i_tok.is_digit ? w_cnt_inc : w_cnt_eff);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= dtsp_pkg::PH_IDLE;
            r_dsc       <= 2'd0;
            r_pivot     <= dtsp_pkg::PIVOT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_dsc       <= n_dsc;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_pivot <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc      <= n_acc;
        r_cnt      <= n_cnt;
        r_month    <= n_month;
        r_day      <= n_day;
        r_year     <= n_year;
        r_hour     <= n_hour;
        r_minute   <= n_minute;
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `DTSP_ASSERT_NOW(a_err_fields_zero, i_clk, i_rst_n, r_out_valid && r_out_data.status, (r_out_data.month == '0) && (r_out_data.day == '0) && (r_out_data.year == '0) && (r_out_data.second == '0) && (r_out_data.consumed_length == '0))
    `DTSP_ASSERT_NOW(a_ok_ranges, i_clk, i_rst_n, r_out_valid && !r_out_data.status, (r_out_data.month != '0) && (r_out_data.month <= 4'd12) && (r_out_data.day != '0) && (r_out_data.hour < 5'd24) && (r_out_data.minute < 6'd60) && (r_out_data.second < 6'd60))
    `DTSP_ASSERT_NEXT(a_result_idles, i_clk, i_rst_n, w_err || w_ok, (r_phase == dtsp_pkg::PH_IDLE) && r_out_valid)
    `DTSP_ASSERT_NOW(a_dsc_range, i_clk, i_rst_n, 1'b1, r_dsc != 2'd3)

endmodule

>>> src/date_time_string_parser.sv
// ---------------------------------------------------------------------------
// date_time_string_parser
// Streaming parser for "mm/dd/yy hh:mi:ss" text, one byte per transaction.
// ---------------------------------------------------------------------------
// Takes one byte per clock while o_in_stall is low: each accepted byte is
// classified and queued, and the parser retires one queued byte per clock
// unless i_out_stall holds a pending result, so sustained rate is one
// transaction per cycle. A result is written to the output register as its
// last byte leaves the queue and holds there until taken. A full queue of
// QUEUE_DEPTH bytes raises o_in_stall. Write year_pivot only while idle.
`timescale 1ns / 1ps

module date_time_string_parser #(
    parameter int LENGTH_BITS = dtsp_pkg::LENGTH_BITS_DEF,
    parameter int QUEUE_DEPTH = dtsp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [6:0]     i_cfg_wdata,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  dtsp_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output dtsp_pkg::t_out o_out_data
);

    dtsp_pkg::t_token w_in_tok;
    dtsp_pkg::t_token w_q_tok;
    logic             w_full;
    logic             w_q_valid;
    logic             w_q_pop;

    assign o_in_stall = w_full;

    dtsp_front u_front (
        .i_data (i_in_data),
        .o_tok  (w_in_tok)
    );

    dtsp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid),
        .i_tok   (w_in_tok),
        .o_full  (w_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_tok   (w_q_tok)
    );

    dtsp_back #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_tok_valid (w_q_valid),
        .i_tok       (w_q_tok),
        .o_tok_pop   (w_q_pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule
